@@ src/qet_pkg.sv @@
// shared types and character codes for the quoted escape tokenizer
package qet_pkg;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_END   = 2'd1,
    KIND_DONE  = 2'd2,
    KIND_ERROR = 2'd3
  } kind_e;

  localparam logic ERR_ESCAPE = 1'b0;
  localparam logic ERR_LENGTH = 1'b1;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_C      = 8'h63;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] token_byte;
    logic       no_line_end;
    logic       error_code;
    logic       last;
  } result_t;

endpackage

@@ src/quoted_escape_tokenizer.sv @@
// quoted escape tokenizer: splits a byte stream into token words
// Takes one script byte per cycle while in_stall_o is low and emits token
// bytes, token ends, done and error words. Each accepted byte is decoded in
// the same cycle against the parser state and produces zero or one result
// word; only the end-of-script item can produce two (token end, then done,
// when a token is open). Results wait in a four-word output queue; the input
// stalls while fewer than two queue slots are free.
// After an error nothing more is produced until an item with start_of_script.
module quoted_escape_tokenizer #(
  parameter int MAX_TOKEN_BYTES = 127
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          byte_in_i,
  input  logic                start_of_script_i,
  input  logic                end_of_script_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output qet_pkg::kind_e      kind_o,
  output logic [7:0]          token_byte_o,
  output logic                no_line_end_o,
  output logic                error_code_o,
  output logic                last_o
);
  import qet_pkg::*;

  localparam logic [7:0] MaxLen = 8'(MAX_TOKEN_BYTES);

  logic       in_quotes_q, in_quotes_d;
  logic       pending_escape_q, pending_escape_d;
  logic [7:0] token_length_q, token_length_d;
  logic       suppress_q, suppress_d;
  logic       failed_q, failed_d;

  result_t    res0, res1;
  logic [1:0] push_n;
  logic       do_app;
  logic [7:0] app_byte;
  logic       is_space;

  result_t    mem_q [4];
  logic [1:0] wr_ptr_q, rd_ptr_q;
  logic [2:0] cnt_q;
  logic       accept, pop;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (cnt_q > 3'd2);
  assign out_valid_o = (cnt_q != 3'd0);
  assign pop        = out_valid_o && !out_stall_i;

  assign kind_o        = mem_q[rd_ptr_q].kind;
  assign token_byte_o  = mem_q[rd_ptr_q].token_byte;
  assign no_line_end_o = mem_q[rd_ptr_q].no_line_end;
  assign error_code_o  = mem_q[rd_ptr_q].error_code;
  assign last_o        = mem_q[rd_ptr_q].last;

  assign is_space = (byte_in_i == CH_SPACE) || (byte_in_i == CH_LF) ||
                    (byte_in_i == CH_CR) || (byte_in_i == CH_TAB);

  always_comb begin
    in_quotes_d      = in_quotes_q;
    pending_escape_d = pending_escape_q;
    token_length_d   = token_length_q;
    suppress_d       = suppress_q;
    failed_d         = failed_q;
    res0             = '0;
    res1             = '0;
    push_n           = 2'd0;
    do_app           = 1'b0;
    app_byte         = byte_in_i;

    if (start_of_script_i) begin
      in_quotes_d      = 1'b0;
      pending_escape_d = 1'b0;
      token_length_d   = '0;
      suppress_d       = 1'b0;
      failed_d         = 1'b0;
    end

    if (!failed_d) begin
      if (end_of_script_i) begin
        // flush the open token, then done, then start over
        if (token_length_d != 8'd0 || in_quotes_d || suppress_d) begin
          res0.kind        = KIND_END;
          res0.no_line_end = suppress_d;
          res1.kind        = KIND_DONE;
          res1.last        = 1'b1;
          push_n           = 2'd2;
        end else begin
          res0.kind = KIND_DONE;
          res0.last = 1'b1;
          push_n    = 2'd1;
        end
        in_quotes_d      = 1'b0;
        pending_escape_d = 1'b0;
        token_length_d   = '0;
        suppress_d       = 1'b0;
      end else if (byte_in_i == CH_BSLASH) begin
        if (in_quotes_d) begin
          do_app = 1'b1;
        end else begin
          do_app           = pending_escape_d;
          pending_escape_d = !pending_escape_d;
        end
      end else if (byte_in_i == CH_QUOTE) begin
        if (pending_escape_d) begin
          do_app           = 1'b1;
          pending_escape_d = 1'b0;
        end else begin
          // closing quote of an empty quoted string
          if (in_quotes_d && token_length_d == 8'd0) begin
            res0.kind        = KIND_END;
            res0.no_line_end = suppress_d;
            res0.last        = 1'b1;
            push_n           = 2'd1;
            suppress_d       = 1'b0;
          end
          in_quotes_d = !in_quotes_d;
        end
      end else if (is_space) begin
        if (in_quotes_d) begin
          do_app = 1'b1;
        end else if (token_length_d != 8'd0 || suppress_d) begin
          res0.kind        = KIND_END;
          res0.no_line_end = suppress_d;
          res0.last        = 1'b1;
          push_n           = 2'd1;
          token_length_d   = '0;
          suppress_d       = 1'b0;
        end
      end else if (pending_escape_d) begin
        pending_escape_d = 1'b0;
        priority if (byte_in_i == CH_N) begin
          do_app   = 1'b1;
          app_byte = CH_LF;
        end else if (byte_in_i == CH_R) begin
          do_app   = 1'b1;
          app_byte = CH_CR;
        end else if (byte_in_i == CH_C) begin
          suppress_d = 1'b1;
        end else begin
          failed_d        = 1'b1;
          res0.kind       = KIND_ERROR;
          res0.error_code = ERR_ESCAPE;
          res0.last       = 1'b1;
          push_n          = 2'd1;
        end
      end else begin
        do_app = 1'b1;
      end

      if (do_app) begin
        push_n    = 2'd1;
        res0.last = 1'b1;
        if (token_length_d >= MaxLen) begin
          failed_d        = 1'b1;
          res0.kind       = KIND_ERROR;
          res0.error_code = ERR_LENGTH;
        end else begin
          token_length_d  = token_length_d + 8'd1;
          res0.kind       = KIND_BYTE;
          res0.token_byte = app_byte;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_quotes_q      <= 1'b0;
      pending_escape_q <= 1'b0;
      token_length_q   <= '0;
      suppress_q       <= 1'b0;
      failed_q         <= 1'b0;
      wr_ptr_q         <= '0;
      rd_ptr_q         <= '0;
      cnt_q            <= '0;
    end else begin
      if (accept) begin
        in_quotes_q      <= in_quotes_d;
        pending_escape_q <= pending_escape_d;
        token_length_q   <= token_length_d;
        suppress_q       <= suppress_d;
        failed_q         <= failed_d;
        wr_ptr_q         <= wr_ptr_q + push_n;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 2'd1;
      end
      cnt_q <= cnt_q + (accept ? 3'(push_n) : 3'd0) - 3'(pop);
    end
  end

  // queue storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept && push_n != 2'd0) begin
      mem_q[wr_ptr_q] <= res0;
    end
    if (accept && push_n == 2'd2) begin
      mem_q[wr_ptr_q + 2'd1] <= res1;
    end
  end

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'd4)
    else $error("output queue overflow");

  a_len_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    token_length_q <= MaxLen)
    else $error("token length beyond limit");

  a_quote_escape : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_quotes_q && pending_escape_q))
    else $error("escape pending inside quotes");

  a_failed_silent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && failed_q && !start_of_script_i) |=> (cnt_q <= $past(cnt_q)))
    else $error("word produced after error");

  a_done_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && end_of_script_i && !failed_d) |=>
      (!in_quotes_q && !pending_escape_q && token_length_q == 8'd0 && !suppress_q))
    else $error("state not cleared after script end");

endmodule

@@ verif/qet_token_checker.sv @@
// checker for the quoted escape tokenizer: predicts result words and compares them
module qet_token_checker #(
  parameter int MAX_TOKEN_BYTES = 127
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_stall_i,
  input  logic [7:0]      byte_in_i,
  input  logic            start_of_script_i,
  input  logic            end_of_script_i,
  input  logic            out_valid_i,
  input  logic            out_stall_i,
  input  qet_pkg::kind_e  kind_i,
  input  logic [7:0]      token_byte_i,
  input  logic            no_line_end_i,
  input  logic            error_code_i,
  input  logic            last_i,
  output int              fail_count_o,
  output int              pending_o,
  output int              live_items_o
);

  timeunit 1ns;
  timeprecision 1ps;

  import qet_pkg::*;

  // tokenizer state as seen from outside
  logic       quoted;
  logic       escape_armed;
  logic [7:0] token_len;
  logic       no_terminator;
  logic       halted;

  result_t expected_words[$];
  result_t item_words[$];
  int      mismatches = 0;
  int      live_items = 0;
  int      waiting = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = waiting;
  assign live_items_o = live_items;

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    if (mismatches < 40)
      $display("%0t ns: mismatch on %s, got %0h want %0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic clear_state();
    quoted        = 1'b0;
    escape_armed  = 1'b0;
    token_len     = 8'd0;
    no_terminator = 1'b0;
    halted        = 1'b0;
  endtask

  task automatic push_word(input kind_e k, input logic [7:0] b, input logic nle,
                           input logic ec);
    item_words.push_back(result_t'{k, b, nle, ec, 1'b0});
  endtask

  task automatic add_byte(input logic [7:0] b);
    if (token_len >= MAX_TOKEN_BYTES) begin
      halted = 1'b1;
      push_word(KIND_ERROR, 8'd0, 1'b0, ERR_LENGTH);
    end else begin
      token_len = token_len + 8'd1;
      push_word(KIND_BYTE, b, 1'b0, 1'b0);
    end
  endtask

  // empty tokens are dropped unless quoted or marked with backslash-c
  task automatic close_token();
    if (token_len != 0 || quoted || no_terminator) begin
      push_word(KIND_END, 8'd0, no_terminator, 1'b0);
      token_len     = 8'd0;
      no_terminator = 1'b0;
    end
  endtask

  task automatic tokenize_word(input logic [7:0] b, input logic sos, input logic eos);
    item_words.delete();
    live_items++;
    if (sos)
      clear_state();
    if (!halted) begin
      if (eos) begin
        close_token();
        push_word(KIND_DONE, 8'd0, 1'b0, 1'b0);
        clear_state();
      end else if (b == CH_BSLASH) begin
        if (quoted) begin
          add_byte(CH_BSLASH);
        end else begin
          if (escape_armed)
            add_byte(CH_BSLASH);
          escape_armed = !escape_armed;
        end
      end else if (b == CH_QUOTE) begin
        if (escape_armed) begin
          add_byte(CH_QUOTE);
          escape_armed = 1'b0;
        end else begin
          if (quoted && token_len == 0)
            close_token();
          quoted = !quoted;
        end
      end else if (b == CH_SPACE || b == CH_LF || b == CH_CR || b == CH_TAB) begin
        // a pending escape survives whitespace
        if (quoted)
          add_byte(b);
        else
          close_token();
      end else if (escape_armed) begin
        escape_armed = 1'b0;
        case (b)
          CH_N: add_byte(CH_LF);
          CH_R: add_byte(CH_CR);
          CH_C: no_terminator = 1'b1;
          default: begin
            halted = 1'b1;
            push_word(KIND_ERROR, 8'd0, 1'b0, ERR_ESCAPE);
          end
        endcase
      end else begin
        add_byte(b);
      end
      if (item_words.size() > 0)
        item_words[item_words.size() - 1].last = 1'b1;
      foreach (item_words[i])
        expected_words.push_back(item_words[i]);
    end
  endtask

  task automatic check_word();
    result_t want;
    if (expected_words.size() == 0) begin
      report_mismatch("word with nothing expected", 8'(kind_i), 8'd0);
      return;
    end
    want = expected_words.pop_front();
    if (kind_i != want.kind)
      report_mismatch("kind", 8'(kind_i), 8'(want.kind));
    if (token_byte_i !== want.token_byte)
      report_mismatch("token_byte", token_byte_i, want.token_byte);
    if (no_line_end_i !== want.no_line_end)
      report_mismatch("no_line_end", 8'(no_line_end_i), 8'(want.no_line_end));
    if (error_code_i !== want.error_code)
      report_mismatch("error_code", 8'(error_code_i), 8'(want.error_code));
    if (last_i !== want.last)
      report_mismatch("last", 8'(last_i), 8'(want.last));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_state();
      expected_words.delete();
    end else begin
      // predict first, then check any word taken from the output
      if (in_valid_i && !in_stall_i)
        tokenize_word(byte_in_i, start_of_script_i, end_of_script_i);
      if (out_valid_i && !out_stall_i)
        check_word();
    end
    waiting = expected_words.size();
  end

endmodule

@@ verif/quoted_escape_tokenizer_tb.sv @@
// testbench top for the quoted escape tokenizer: stimulus, stalls and verdict
module quoted_escape_tokenizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import qet_pkg::*;

  localparam int         MAX_TOKEN_BYTES = 127;
  localparam int         LIVE_ITEM_TARGET = 1000;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_Z = 8'h7A;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic       in_sos;
  logic       in_eos;
  logic       out_valid;
  logic       out_stall;
  kind_e      out_kind;
  logic [7:0] out_token_byte;
  logic       out_no_line_end;
  logic       out_error_code;
  logic       out_last;

  int fail_count;
  int pending;
  int live_items;

  bit sos_next;
  bit no_gaps;

  always #5 clk = ~clk;

  quoted_escape_tokenizer #(
    .MAX_TOKEN_BYTES(MAX_TOKEN_BYTES)
  ) u_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .byte_in_i        (in_byte),
    .start_of_script_i(in_sos),
    .end_of_script_i  (in_eos),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .kind_o           (out_kind),
    .token_byte_o     (out_token_byte),
    .no_line_end_o    (out_no_line_end),
    .error_code_o     (out_error_code),
    .last_o           (out_last)
  );

  qet_token_checker #(
    .MAX_TOKEN_BYTES(MAX_TOKEN_BYTES)
  ) u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .byte_in_i        (in_byte),
    .start_of_script_i(in_sos),
    .end_of_script_i  (in_eos),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .kind_i           (out_kind),
    .token_byte_i     (out_token_byte),
    .no_line_end_i    (out_no_line_end),
    .error_code_i     (out_error_code),
    .last_i           (out_last),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .live_items_o     (live_items)
  );

  // any byte that is not a quote, backslash or whitespace
  function automatic logic [7:0] plain_char();
    logic [7:0] b;
    do
      b = 8'($urandom_range(0, 255));
    while (b == CH_BSLASH || b == CH_QUOTE || b == CH_SPACE || b == CH_LF ||
           b == CH_CR || b == CH_TAB);
    return b;
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 3))
      0:       return CH_SPACE;
      1:       return CH_LF;
      2:       return CH_CR;
      default: return CH_TAB;
    endcase
  endfunction

  // sender side: optional gap, then hold the word until it is taken
  task automatic send_item(input logic [7:0] b, input logic eos);
    int r;
    int gap;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55)
      gap = 0;
    else if (r < 85)
      gap = $urandom_range(1, 3);
    else if (r < 97)
      gap = $urandom_range(4, 10);
    else
      gap = $urandom_range(20, 60);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_byte  = b;
    in_sos   = sos_next;
    in_eos   = eos;
    sos_next = 1'b0;
    do
      @(posedge clk);
    while (in_stall);
    @(negedge clk);
  endtask

  // one script: mostly well-formed pieces, some noise and broken escapes
  task automatic play_script();
    int         pieces;
    int         r;
    int         n;
    logic [7:0] b;
    sos_next = 1'b1;
    no_gaps  = ($urandom_range(0, 3) == 0);
    pieces   = $urandom_range(1, 16);
    repeat (pieces) begin
      if ($urandom_range(0, 49) == 0)
        sos_next = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 35) begin
        n = $urandom_range(1, 6);
        repeat (n) send_item(plain_char(), 1'b0);
      end else if (r < 50) begin
        send_item(blank_char(), 1'b0);
      end else if (r < 62) begin
        send_item(CH_QUOTE, 1'b0);
        n = $urandom_range(0, 5);
        repeat (n) begin
          case ($urandom_range(0, 3))
            0, 1:    send_item(plain_char(), 1'b0);
            2:       send_item(blank_char(), 1'b0);
            default: send_item(CH_BSLASH, 1'b0);
          endcase
        end
        send_item(CH_QUOTE, 1'b0);
      end else if (r < 75) begin
        send_item(CH_BSLASH, 1'b0);
        case ($urandom_range(0, 4))
          0:       send_item(CH_BSLASH, 1'b0);
          1:       send_item(CH_QUOTE, 1'b0);
          2:       send_item(CH_N, 1'b0);
          3:       send_item(CH_R, 1'b0);
          default: send_item(CH_C, 1'b0);
        endcase
      end else if (r < 81) begin
        send_item(8'($urandom_range(0, 255)), 1'b0);
      end else if (r < 84) begin
        do
          b = 8'($urandom_range(CH_LOW_A, CH_LOW_Z));
        while (b == CH_N || b == CH_R || b == CH_C);
        send_item(CH_BSLASH, 1'b0);
        send_item(b, 1'b0);
      end else if (r < 85) begin
        // runs up to and past the token length limit
        n = $urandom_range(MAX_TOKEN_BYTES - 8, MAX_TOKEN_BYTES + 8);
        repeat (n) send_item(plain_char(), 1'b0);
      end else if (r < 91) begin
        send_item(CH_QUOTE, 1'b0);
        send_item(CH_QUOTE, 1'b0);
      end else begin
        send_item(($urandom_range(0, 1) == 0) ? CH_BSLASH : CH_QUOTE, 1'b0);
      end
    end
    if ($urandom_range(0, 9) != 0) begin
      if ($urandom_range(0, 19) == 0)
        sos_next = 1'b1;
      send_item(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_byte  = 8'd0;
    in_sos   = 1'b0;
    in_eos   = 1'b0;
    sos_next = 1'b0;
    no_gaps  = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // byte extremes, whitespace ends a token, quoted empty string
    sos_next = 1'b1;
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(CH_TAB, 1'b0);
    send_item(CH_QUOTE, 1'b0);
    send_item(CH_QUOTE, 1'b0);
    // backslash inside quotes is literal
    send_item(CH_QUOTE, 1'b0);
    send_item(CH_BSLASH, 1'b0);
    send_item(CH_QUOTE, 1'b0);
    send_item(CH_CR, 1'b0);
    // escapes, an escape held across whitespace, backslash-c then terminator
    send_item(CH_BSLASH, 1'b0);
    send_item(CH_BSLASH, 1'b0);
    send_item(CH_BSLASH, 1'b0);
    send_item(CH_QUOTE, 1'b0);
    send_item(CH_BSLASH, 1'b0);
    send_item(CH_N, 1'b0);
    send_item(CH_BSLASH, 1'b0);
    send_item(CH_SPACE, 1'b0);
    send_item(CH_R, 1'b0);
    send_item(CH_BSLASH, 1'b0);
    send_item(CH_C, 1'b0);
    send_item(8'h5A, 1'b1);
    // invalid escape, then everything is ignored up to the next script
    sos_next = 1'b1;
    send_item(CH_BSLASH, 1'b0);
    send_item(CH_LOW_Z, 1'b0);
    send_item(8'hA5, 1'b1);
    // terminator inside quotes, then terminator with an escape pending
    sos_next = 1'b1;
    send_item(CH_QUOTE, 1'b0);
    send_item(8'h00, 1'b1);
    sos_next = 1'b1;
    send_item(CH_BSLASH, 1'b0);
    send_item(8'hFF, 1'b1);

    while (live_items < LIVE_ITEM_TARGET)
      play_script();
    in_valid = 1'b0;

    while (pending != 0)
      @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  // receiver side: random stalls, one long hold-off early on
  task automatic stall_burst();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      out_stall = 1'b0;
      n = $urandom_range(1, 8);
    end else if (r < 85) begin
      out_stall = 1'b1;
      n = $urandom_range(1, 3);
    end else if (r < 95) begin
      out_stall = 1'b1;
      n = $urandom_range(10, 40);
    end else begin
      out_stall = 1'b0;
      n = $urandom_range(50, 100);
    end
    repeat (n) @(negedge clk);
  endtask

  initial begin
    int hold_cycles;
    out_stall = 1'b0;
    @(posedge rst_n);
    repeat (40) stall_burst();
    // sender keeps offering words while the output is blocked
    out_stall = 1'b1;
    hold_cycles = 0;
    while (hold_cycles < 400) begin
      @(negedge clk);
      hold_cycles++;
    end
    forever stall_burst();
  end

  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

@@ filelist.f @@
src/qet_pkg.sv
src/quoted_escape_tokenizer.sv
verif/qet_token_checker.sv
verif/quoted_escape_tokenizer_tb.sv
